[hdl/ps_pkg.sv]
// Shared constants and types for the Phong shading pipeline.
package ps_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int EXPONENT_BITS_DEF  = 8;
    localparam int VEC_FRAC           = 14;
    localparam int GAIN_FRAC          = 14;
    localparam int COLOR_FRAC         = 12;
    localparam int LANES              = 3;
    localparam int PRE_STAGES         = 6;
    localparam int POST_STAGES        = 2;

    localparam logic [31:0] VEC_CAP   = 32'h8000_0000;
    localparam logic [31:0] Q14_ONE   = 32'h0000_4000;

    typedef struct packed {
        logic lit;
        logic spec_on;
    } ps_flags_t;

endpackage

[hdl/ps_geom.sv]
// Geometry stages: light.normal, reflected vector, reflect.(-eye).
module ps_geom
    import ps_pkg::*;
#(
    parameter int CB = COMPONENT_BITS_DEF,
    parameter int EB = EXPONENT_BITS_DEF
)
(
    input  logic          clk,
    input  logic [EB+7:0] en,
    input  logic [47:0]   light_dir,
    input  logic [47:0]   normal_dir,
    input  logic [47:0]   eye_dir,
    input  logic          shadow_flag,
    input  logic [EB-1:0] expo_in,
    output logic [31:0]   ldn,
    output logic [31:0]   base,
    output logic [EB-1:0] expo,
    output ps_flags_t     flags
);

    localparam int SW = (2*CB+2 > 34) ? 2*CB+2 : 34;
    localparam int TW = CB + 34;
    localparam int RW = CB + 36;

    localparam logic signed [SW-1:0] CAP_S = $signed({{(SW-33){1'b0}}, 33'h0_8000_0000});
    localparam logic signed [TW-1:0] CAP_T = $signed({{(TW-33){1'b0}}, 33'h0_8000_0000});
    localparam logic signed [RW-1:0] CAP_R = $signed({{(RW-33){1'b0}}, 33'h0_8000_0000});
    localparam logic signed [32:0]   CAP33 = 33'sh0_8000_0000;

    logic [3*CB+47:0] ld_w, nd_w, ed_w;
    logic signed [CB-1:0] lv [LANES];
    logic signed [CB-1:0] nv [LANES];
    logic signed [CB:0]   ev [LANES];

    assign ld_w = {{(3*CB){1'b0}}, light_dir};
    assign nd_w = {{(3*CB){1'b0}}, normal_dir};
    assign ed_w = {{(3*CB){1'b0}}, eye_dir};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lv[i] = $signed(ld_w[i*CB +: CB]);
            nv[i] = $signed(nd_w[i*CB +: CB]);
            ev[i] = -$signed({ed_w[i*CB+CB-1], ed_w[i*CB +: CB]});
        end
    end

    // stage 0: component products of light and normal
    logic signed [CB-1:0]   lv0_reg [LANES];
    logic signed [CB-1:0]   nv0_reg [LANES];
    logic signed [CB:0]     ev0_reg [LANES];
    logic signed [2*CB-1:0] pl0_reg [LANES];
    logic                   shd0_reg;
    logic [EB-1:0]          ex_reg [0:PRE_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lv0_reg[i] <= lv[i];
                nv0_reg[i] <= nv[i];
                ev0_reg[i] <= ev[i];
                pl0_reg[i] <= lv[i] * nv[i];
            end
            shd0_reg  <= shadow_flag;
            ex_reg[0] <= expo_in;
        end
    end

    for (genvar k = 1; k < PRE_STAGES; k++)
    begin : g_ex
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                ex_reg[k] <= ex_reg[k-1];
            end
        end
    end

    // stage 1: sum, floor shift and clamp to get light.normal
    logic signed [SW-1:0] sum1, sh1;
    logic signed [32:0]   ldn_next;
    logic signed [32:0]   ldn1_reg;
    logic                 lit1_reg;
    logic signed [CB-1:0] lv1_reg [LANES];
    logic signed [CB-1:0] nv1_reg [LANES];
    logic signed [CB:0]   ev1_reg [LANES];

    always_comb
    begin
        sum1 = pl0_reg[0] + pl0_reg[1] + pl0_reg[2];
        sh1  = sum1 >>> VEC_FRAC;
        if (sh1 > CAP_S)
            ldn_next = CAP33;
        else if (sh1 < -CAP_S)
            ldn_next = -CAP33;
        else
            ldn_next = sh1[32:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ldn1_reg <= ldn_next;
            lit1_reg <= !shd0_reg && !ldn_next[32];
            for (int i = 0; i < LANES; i++)
            begin
                lv1_reg[i] <= lv0_reg[i];
                nv1_reg[i] <= nv0_reg[i];
                ev1_reg[i] <= ev0_reg[i];
            end
        end
    end

    // stage 2: (L.N) * N
    logic signed [CB+32:0] q2_reg  [LANES];
    logic signed [CB-1:0]  lv2_reg [LANES];
    logic signed [CB:0]    ev2_reg [LANES];
    logic signed [32:0]    ldn2_reg;
    logic                  lit2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                q2_reg[i]  <= ldn1_reg * nv1_reg[i];
                lv2_reg[i] <= lv1_reg[i];
                ev2_reg[i] <= ev1_reg[i];
            end
            ldn2_reg <= ldn1_reg;
            lit2_reg <= lit1_reg;
        end
    end

    assign ldn = ldn2_reg[31:0];

    // stage 3: reflected vector r = L - 2(L.N)N, clamped
    logic signed [TW-1:0] t3 [LANES];
    logic signed [32:0]   rv_next [LANES];
    logic signed [32:0]   rv3_reg [LANES];
    logic signed [CB:0]   ev3_reg [LANES];
    logic                 lit3_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            t3[i] = lv2_reg[i] - (q2_reg[i] >>> (VEC_FRAC - 1));
            if (t3[i] > CAP_T)
                rv_next[i] = CAP33;
            else if (t3[i] < -CAP_T)
                rv_next[i] = -CAP33;
            else
                rv_next[i] = t3[i][32:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                rv3_reg[i] <= rv_next[i];
                ev3_reg[i] <= ev2_reg[i];
            end
            lit3_reg <= lit2_reg;
        end
    end

    // stage 4: component products of r and -eye
    logic signed [CB+33:0] re4_reg [LANES];
    logic                  lit4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                re4_reg[i] <= rv3_reg[i] * ev3_reg[i];
            end
            lit4_reg <= lit3_reg;
        end
    end

    // stage 5: reflect.(-eye), clamp, decide on the specular term
    logic signed [RW-1:0] sum5, sh5;
    logic signed [32:0]   rde_next;
    logic [31:0]          base5_reg;
    ps_flags_t            fl5_reg;

    always_comb
    begin
        sum5 = re4_reg[0] + re4_reg[1] + re4_reg[2];
        sh5  = sum5 >>> VEC_FRAC;
        if (sh5 > CAP_R)
            rde_next = CAP33;
        else if (sh5 < -CAP_R)
            rde_next = -CAP33;
        else
            rde_next = sh5[32:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            base5_reg       <= rde_next[31:0];
            fl5_reg.lit     <= lit4_reg;
            fl5_reg.spec_on <= lit4_reg && !rde_next[32] && (rde_next != 33'sd0);
        end
    end

    assign base  = base5_reg;
    assign flags = fl5_reg;
    assign expo  = ex_reg[PRE_STAGES-1];

endmodule

[hdl/ps_power.sv]
// Square-and-multiply power pipeline, one exponent bit per stage.
module ps_power
    import ps_pkg::*;
#(
    parameter int CB = COMPONENT_BITS_DEF,
    parameter int EB = EXPONENT_BITS_DEF
)
(
    input  logic          clk,
    input  logic [EB+7:0] en,
    input  logic [31:0]   base_in,
    input  logic [EB-1:0] expo_in,
    input  ps_flags_t     flags_in,
    output logic [31:0]   pw,
    output ps_flags_t     flags
);

    localparam int HW = 64 - VEC_FRAC;
    localparam logic [HW-1:0] CAP_H = HW'(VEC_CAP);

    logic [31:0]   acc_reg [EB];
    logic [31:0]   bas_reg [EB-1];
    logic [EB-1:0] ex_reg  [EB-1];
    ps_flags_t     fl_reg  [EB];

    for (genvar j = 0; j < EB; j++)
    begin : g_stage
        logic [31:0]   acc_i, bas_i, acc_next;
        logic [EB-1:0] ex_i;
        ps_flags_t     fl_i;
        logic [63:0]   pa;

        if (j == 0)
        begin : g_first
            assign acc_i = Q14_ONE;
            assign bas_i = base_in;
            assign ex_i  = expo_in;
            assign fl_i  = flags_in;
        end
        else
        begin : g_rest
            assign acc_i = acc_reg[j-1];
            assign bas_i = bas_reg[j-1];
            assign ex_i  = ex_reg[j-1];
            assign fl_i  = fl_reg[j-1];
        end

        assign pa = acc_i * bas_i;
        assign acc_next = !ex_i[j] ? acc_i :
                          (pa[63:VEC_FRAC] > CAP_H) ? VEC_CAP : pa[VEC_FRAC+31:VEC_FRAC];

        always_ff @(posedge clk)
        begin
            if (en[PRE_STAGES+j])
            begin
                acc_reg[j] <= acc_next;
                fl_reg[j]  <= fl_i;
            end
        end

        // square the base for the next bit; the last stage has no successor
        if (j < EB - 1)
        begin : g_square
            logic [63:0] pb;
            assign pb = bas_i * bas_i;
            always_ff @(posedge clk)
            begin
                if (en[PRE_STAGES+j])
                begin
                    bas_reg[j] <= (pb[63:VEC_FRAC] > CAP_H) ? VEC_CAP
                                                            : pb[VEC_FRAC+31:VEC_FRAC];
                    ex_reg[j]  <= ex_i;
                end
            end
        end
    end

    assign pw    = acc_reg[EB-1];
    assign flags = fl_reg[EB-1];

endmodule

[hdl/ps_color.sv]
// Color stages: ambient, diffuse and specular terms and the saturating sum.
module ps_color
    import ps_pkg::*;
#(
    parameter int CB = COMPONENT_BITS_DEF,
    parameter int EB = EXPONENT_BITS_DEF
)
(
    input  logic          clk,
    input  logic [EB+7:0] en,
    input  logic [47:0]   surface_rgb,
    input  logic [47:0]   light_rgb,
    input  logic [15:0]   ambient_gain,
    input  logic [15:0]   diffuse_gain,
    input  logic [15:0]   specular_gain,
    input  logic [31:0]   ldn,
    input  logic [31:0]   pw,
    input  ps_flags_t     flags,
    output logic [47:0]   out_rgb
);

    localparam int EW  = 2*CB - COLOR_FRAC;
    localparam int AW  = EW + 16 - GAIN_FRAC;
    localparam int XW  = (AW > CB + 15) ? AW : CB + 15;
    localparam int SPW = CB + 2;
    localparam int ST_MUL = PRE_STAGES + EB;
    localparam int ST_OUT = ST_MUL + 1;

    localparam logic [CB:0]    M_TERM = {1'b1, {CB{1'b0}}};
    localparam logic [CB+14:0] D_CAP  = {1'b1, {(CB+14){1'b0}}};
    localparam logic [CB+2:0]  MASK_W = {3'b000, {CB{1'b1}}};

    logic [3*CB+47:0] s_w, l_w;
    logic [CB-1:0]    s_l [LANES];
    logic [CB-1:0]    l_l [LANES];

    assign s_w = {{(3*CB){1'b0}}, surface_rgb};
    assign l_w = {{(3*CB){1'b0}}, light_rgb};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            s_l[i] = s_w[i*CB +: CB];
            l_l[i] = l_w[i*CB +: CB];
        end
    end

    // stage 0: effective color and scaled specular color
    logic [2*CB-1:0]   se [LANES];
    logic [CB+15:0]    sl [LANES];
    logic [EW-1:0]     eff0_reg [LANES];
    logic [SPW-1:0]    sp_reg [LANES][0:ST_MUL-1];
    logic [15:0]       ag0_reg, dg0_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            se[i] = s_l[i] * l_l[i];
            sl[i] = l_l[i] * specular_gain;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                eff0_reg[i] <= se[i][2*CB-1:COLOR_FRAC];
            end
            ag0_reg <= ambient_gain;
            dg0_reg <= diffuse_gain;
        end
    end

    // carry the scaled specular color alongside the power chain
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sp_reg[i][0] <= sl[i][CB+15:GAIN_FRAC];
            end
        end
        for (int k = 1; k < ST_MUL; k++)
        begin
            if (en[k])
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    sp_reg[i][k] <= sp_reg[i][k-1];
                end
            end
        end
    end

    // stage 1: gain products
    logic [EW+15:0] ambp1_reg [LANES];
    logic [EW+15:0] difp1_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                ambp1_reg[i] <= eff0_reg[i] * ag0_reg;
                difp1_reg[i] <= eff0_reg[i] * dg0_reg;
            end
        end
    end

    // stage 2: cap ambient and the diffuse partial, beyond which the result saturates anyway
    logic [AW-1:0]   ash [LANES];
    logic [XW-1:0]   dsh [LANES];
    logic [CB:0]     amb_reg [LANES][2:ST_OUT-1];
    logic [CB+14:0]  dc2_reg [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ash[i] = ambp1_reg[i][EW+15:GAIN_FRAC];
            dsh[i] = XW'(difp1_reg[i][EW+15:GAIN_FRAC]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                dc2_reg[i] <= (dsh[i] > XW'(D_CAP)) ? D_CAP : dsh[i][CB+14:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                amb_reg[i][2] <= (ash[i] > AW'(M_TERM)) ? M_TERM : ash[i][CB:0];
            end
        end
        for (int k = 3; k < ST_OUT; k++)
        begin
            if (en[k])
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    amb_reg[i][k] <= amb_reg[i][k-1];
                end
            end
        end
    end

    // stage 3: scale by light.normal
    logic [CB+46:0] dl3_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                dl3_reg[i] <= dc2_reg[i] * ldn;
            end
        end
    end

    // stage 4: diffuse term, capped
    logic [CB+32:0] dfs [LANES];
    logic [CB:0]    dif_reg [LANES][4:ST_OUT-1];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            dfs[i] = dl3_reg[i][CB+46:VEC_FRAC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                dif_reg[i][4] <= (dfs[i] > (CB+33)'(M_TERM)) ? M_TERM : dfs[i][CB:0];
            end
        end
        for (int k = 5; k < ST_OUT; k++)
        begin
            if (en[k])
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    dif_reg[i][k] <= dif_reg[i][k-1];
                end
            end
        end
    end

    // multiply stage: specular color times power
    logic [CB+33:0] spp_reg [LANES];
    ps_flags_t      fl_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                spp_reg[i] <= sp_reg[i][ST_MUL-1] * pw;
            end
            fl_reg <= flags;
        end
    end

    // output stage: add the terms and saturate each channel
    logic [CB+19:0] sps [LANES];
    logic [CB:0]    spt [LANES];
    logic [CB+2:0]  tot [LANES];
    logic [CB+15:0] res [LANES];
    logic [47:0]    out_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sps[i] = spp_reg[i][CB+33:VEC_FRAC];
            spt[i] = (sps[i] > (CB+20)'(M_TERM)) ? M_TERM : sps[i][CB:0];
            tot[i] = (CB+3)'(amb_reg[i][ST_OUT-1])
                   + (fl_reg.lit ? (CB+3)'(dif_reg[i][ST_OUT-1]) : '0)
                   + (fl_reg.spec_on ? (CB+3)'(spt[i]) : '0);
            res[i] = {16'h0000, ((tot[i] > MASK_W) ? MASK_W[CB-1:0] : tot[i][CB-1:0])};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            out_reg <= {res[2][15:0], res[1][15:0], res[0][15:0]};
        end
    end

    assign out_rgb = out_reg;

endmodule

[hdl/phong_shade.sv]
// Phong shader top level: handshake, stage valid bits and the three pipelines.
//
//  channel   dir  signals                                  item
//  s_axis    in   tvalid tready tdata[295:0] tuser[0]      one surface point
//  m_axis    out  tvalid tready tdata[47:0]                one shaded color
//
//  The pipeline has six geometry stages, one stage per exponent bit in the power chain,
//  and two color stages; one item per cycle while no stall holds the flow.
//  Reset clears only the stage valid bits.
//  Each stage holds while it is full and the next stage cannot take its item;
//  empty stages keep filling, so input is taken while a result waits.
module phong_shade
    import ps_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int EXPONENT_BITS  = EXPONENT_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // surface_rgb[47:0] light_rgb[95:48] light_dir[143:96] normal_dir[191:144]
    // eye_dir[239:192] ambient_gain[255:240] diffuse_gain[271:256]
    // specular_gain[287:272] shine_exponent[295:288]
    input  logic [295:0] s_axis_tdata,
    // shadow_flag[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_red[15:0] out_green[31:16] out_blue[47:32]
    output logic [47:0]  m_axis_tdata
);

    localparam int EB  = EXPONENT_BITS;
    localparam int NST = PRE_STAGES + EB + POST_STAGES;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;

    // a stage may load when the output is ready or when it or any stage after it has room
    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            en[k] = m_axis_tready || (((~v_reg) >> k) != '0);
        end
    end

    assign v_next = {v_reg[NST-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_next[k];
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[NST-1];

    logic [EB+7:0] ex_w;
    logic [EB-1:0] expo_in, expo_g;
    logic [31:0]   ldn, base, pw;
    ps_flags_t     fl_g, fl_p;

    assign ex_w    = {{EB{1'b0}}, s_axis_tdata[295:288]};
    assign expo_in = ex_w[EB-1:0];

    ps_geom #(.CB(COMPONENT_BITS), .EB(EB)) u_geom (
        .clk         (clk),
        .en          (en),
        .light_dir   (s_axis_tdata[143:96]),
        .normal_dir  (s_axis_tdata[191:144]),
        .eye_dir     (s_axis_tdata[239:192]),
        .shadow_flag (s_axis_tuser),
        .expo_in     (expo_in),
        .ldn         (ldn),
        .base        (base),
        .expo        (expo_g),
        .flags       (fl_g)
    );

    ps_power #(.CB(COMPONENT_BITS), .EB(EB)) u_power (
        .clk        (clk),
        .en         (en),
        .base_in    (base),
        .expo_in    (expo_g),
        .flags_in   (fl_g),
        .pw         (pw),
        .flags      (fl_p)
    );

    ps_color #(.CB(COMPONENT_BITS), .EB(EB)) u_color (
        .clk           (clk),
        .en            (en),
        .surface_rgb   (s_axis_tdata[47:0]),
        .light_rgb     (s_axis_tdata[95:48]),
        .ambient_gain  (s_axis_tdata[255:240]),
        .diffuse_gain  (s_axis_tdata[271:256]),
        .specular_gain (s_axis_tdata[287:272]),
        .ldn           (ldn),
        .pw            (pw),
        .flags         (fl_p),
        .out_rgb       (m_axis_tdata)
    );

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_result_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST-2] && en[NST-1] |=> m_axis_tvalid)
        else $error("item lost entering the output stage");

    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !v_reg[NST-2] |=> !m_axis_tvalid)
        else $error("item repeated at the output");

endmodule

[test/phong_shade_chk.sv]
// Checker for the Phong shader: watches both channels, predicts each color and compares.
`timescale 1ns / 100ps
module phong_shade_chk
    import ps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [295:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [47:0]  m_axis_tdata,
    output int           fail_count,
    output int           pending
);

    localparam longint CAP = 64'sd2147483648;
    localparam logic [63:0] U64_MAX = '1;

    logic [47:0] color_queue[$];

    function automatic longint lane_signed(logic [47:0] v, int i);
        logic signed [15:0] c;
        c = v[i*16 +: 16];
        return longint'(c);
    endfunction

    // floor division by 2^k on a signed value
    function automatic longint floor_sh(longint p, int k);
        return p >>> k;
    endfunction

    function automatic longint clamp_cap(longint x);
        if (x > CAP) return CAP;
        if (x < -CAP) return -CAP;
        return x;
    endfunction

    function automatic longint dot_q14(longint a[3], longint b[3]);
        logic signed [127:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += 128'(signed'(a[i])) * 128'(signed'(b[i]));
        acc = acc >>> VEC_FRAC;
        if (acc > CAP) return CAP;
        if (acc < -CAP) return -CAP;
        return longint'(acc);
    endfunction

    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return (p[127:64] != 0) ? U64_MAX : p[63:0];
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = a + b;
        return s[64] ? U64_MAX : s[63:0];
    endfunction

    function automatic logic [63:0] power_q14(logic [63:0] base, logic [7:0] ex);
        logic [63:0] acc;
        acc = 64'(Q14_ONE);
        if (base > 64'(VEC_CAP)) base = 64'(VEC_CAP);
        for (int i = 0; i < 8; i++) begin
            if (ex[i])
            begin
                acc = (acc * base) >> VEC_FRAC;
                if (acc > 64'(VEC_CAP)) acc = 64'(VEC_CAP);
            end
            base = (base * base) >> VEC_FRAC;
            if (base > 64'(VEC_CAP)) base = 64'(VEC_CAP);
        end
        return acc;
    endfunction

    function automatic logic [47:0] shade_point(logic [295:0] d, logic shadow);
        longint lv[3], nv[3], ev[3], rv[3];
        longint ldn, rde;
        logic [63:0] pw, s, l, eff, sum, dterm, sp;
        logic lit, spec;
        logic [47:0] res;
        for (int i = 0; i < 3; i++)
        begin
            lv[i] = lane_signed(d[143:96], i);
            nv[i] = lane_signed(d[191:144], i);
            ev[i] = -lane_signed(d[239:192], i);
        end
        ldn = dot_q14(lv, nv);
        lit = !shadow && ldn >= 0;
        spec = 1'b0;
        pw = 0;
        if (lit)
        begin
            for (int i = 0; i < 3; i++)
                rv[i] = clamp_cap(lv[i] - floor_sh(ldn * nv[i], VEC_FRAC - 1));
            rde = dot_q14(rv, ev);
            if (rde > 0)
            begin
                spec = 1'b1;
                pw = power_q14(64'(rde), d[295:288]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            s = 64'(d[i*16 +: 16]);
            l = 64'(d[48 + i*16 +: 16]);
            eff = mul_sat(s, l) >> COLOR_FRAC;
            sum = mul_sat(eff, 64'(d[255:240])) >> GAIN_FRAC;
            if (lit)
            begin
                dterm = mul_sat(eff, 64'(d[271:256])) >> GAIN_FRAC;
                sum = add_sat(sum, mul_sat(dterm, 64'(ldn)) >> VEC_FRAC);
                if (spec)
                begin
                    sp = mul_sat(l, 64'(d[287:272])) >> GAIN_FRAC;
                    sum = add_sat(sum, mul_sat(sp, pw) >> VEC_FRAC);
                end
            end
            if (sum > 64'hFFFF) sum = 64'hFFFF;
            res[i*16 +: 16] = sum[15:0];
        end
        return res;
    endfunction

    assign pending = color_queue.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        logic [47:0] want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                color_queue.push_back(shade_point(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (color_queue.size() == 0)
                begin
                    $error("unexpected color %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = color_queue.pop_front();
                    if (want[15:0] != m_axis_tdata[15:0])
                    begin
                        $error("out_red expected %h got %h", want[15:0], m_axis_tdata[15:0]);
                        fail_count++;
                    end
                    if (want[31:16] != m_axis_tdata[31:16])
                    begin
                        $error("out_green expected %h got %h", want[31:16],
                               m_axis_tdata[31:16]);
                        fail_count++;
                    end
                    if (want[47:32] != m_axis_tdata[47:32])
                    begin
                        $error("out_blue expected %h got %h", want[47:32],
                               m_axis_tdata[47:32]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[test/phong_shade_tb.sv]
// Testbench top for the Phong shader: stimulus, idling, hold-off and verdict.
`timescale 1ns / 100ps
module phong_shade_tb;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [295:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    int           fail_count;
    int           pending;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_off;

    phong_shade uut (.*);

    phong_shade_chk chk (.*);

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        int hold;
        hold_off = 1'b0;
        wait (send_idle_pct == 0 && rst_n);
        hold_off = 1'b1;
        hold = 0;
        while (hold < 60)
        begin
            @(posedge clk);
            hold++;
        end
        hold_off = 1'b0;
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // unit-ish vector with given components in Q2.14
    function automatic logic [47:0] vec3(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [47:0] near_unit();
        int ax, sign;
        ax = $urandom_range(5);
        sign = $urandom_range(1) ? -16384 : 16384;
        case (ax)
            0: return vec3(sign, 0, 0);
            1: return vec3(0, sign, 0);
            2: return vec3(0, 0, sign);
            default: return vec3(11585 * ($urandom_range(1) ? -1 : 1),
                                 11585 * ($urandom_range(1) ? -1 : 1), 0);
        endcase
    endfunction

    task automatic send_point(logic [47:0] surf, logic [47:0] lrgb, logic [47:0] ldir,
                              logic [47:0] ndir, logic [47:0] edir, logic shadow,
                              logic [15:0] ag, logic [15:0] dg, logic [15:0] sg,
                              logic [7:0] ex);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ex, sg, dg, ag, edir, ndir, ldir, lrgb, surf};
        s_axis_tuser  <= shadow;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random();
        int kind;
        logic [47:0] l, n, e;
        kind = $urandom_range(9);
        if (kind < 7)
        begin
            l = near_unit();
            n = near_unit();
            e = near_unit();
        end
        else
        begin
            l = rand48();
            n = rand48();
            e = rand48();
        end
        send_point(kind == 9 ? rand48() : {3{16'($urandom_range(8192))}} ^ 48'($urandom),
                   rand48(), l, n, e, $urandom_range(3) == 0, 16'($urandom),
                   16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int cnt;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 58;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: head-on light with highlight, eye opposite, grazing, light behind, shadow, extremes
        send_point({3{16'h1000}}, {3{16'h1000}}, vec3(0, 0, 16384), vec3(0, 0, 16384),
                   vec3(0, 0, 16384), 1'b0, 16'h4000, 16'h4000, 16'h4000, 8'd1);
        send_point({3{16'h1000}}, {3{16'h1000}}, vec3(0, 0, 16384), vec3(0, 0, 16384),
                   vec3(0, 0, -16384), 1'b0, 16'h1000, 16'h4000, 16'h4000, 8'd255);
        send_point({3{16'h1000}}, {3{16'h1000}}, vec3(16384, 0, 0), vec3(0, 0, 16384),
                   vec3(0, 0, 16384), 1'b0, 16'h1000, 16'h4000, 16'h4000, 8'd8);
        send_point({3{16'h1000}}, {3{16'h1000}}, vec3(0, 0, -16384), vec3(0, 0, 16384),
                   vec3(0, 0, 16384), 1'b0, 16'h1000, 16'h4000, 16'h4000, 8'd8);
        send_point({3{16'h1000}}, {3{16'h1000}}, vec3(0, 0, 16384), vec3(0, 0, 16384),
                   vec3(0, 0, -16384), 1'b1, 16'h1000, 16'h4000, 16'h4000, 8'd8);
        send_point('1, '1, '1, '1, '1, 1'b0, '1, '1, '1, '1);
        send_point('0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
        send_point('1, '1, vec3(-32768, -32768, -32768), vec3(-32768, -32768, -32768),
                   vec3(32767, 32767, 32767), 1'b0, '1, '1, '1, 8'd0);
        send_point('1, '1, vec3(32767, 32767, 32767), vec3(32767, 32767, 32767),
                   vec3(-32768, -32768, -32768), 1'b0, '1, '1, '1, 8'd3);
        send_point('1, '1, '0, '0, '0, 1'b1, '1, '1, '1, 8'd128);
        send_point({3{16'h8000}}, {3{16'h8000}}, vec3(11585, 0, 11585), vec3(0, 0, 16384),
                   vec3(11585, 0, -11585), 1'b0, 16'h8000, 16'h8000, 16'h8000, 8'd2);

        for (cnt = 0; cnt < 150; cnt++) send_random();
        send_idle_pct = 58;
        recv_idle_pct = 30;
        for (cnt = 0; cnt < 150; cnt++) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (cnt = 0; cnt < 150; cnt++) send_random();
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[phong_shade.f]
hdl/ps_pkg.sv
hdl/ps_geom.sv
hdl/ps_power.sv
hdl/ps_color.sv
hdl/phong_shade.sv
test/phong_shade_chk.sv
test/phong_shade_tb.sv
